>>> hdl/nmit_pkg.sv
// Shared types and widths for the normal matrix inverse transpose pipeline.
package nmit_pkg;

  localparam int ELEM_W = 32;
  localparam int COF_W  = 64;
  localparam int DET_W  = 128;
  localparam int THR_W  = 31;
  localparam int QUO_W  = 32;
  localparam int LANES  = 9;
  localparam logic [THR_W-1:0] THR_RESET = 31'd17;

  typedef logic [LANES-1:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    logic                        valid;
    mat_t                        m;
    logic [LANES-1:0][COF_W-1:0] cof;
  } nmit_cof_t;

  typedef struct packed {
    logic                        valid;
    logic                        singular;
    mat_t                        m;
    logic [DET_W-1:0]            d;
    logic [LANES-1:0][COF_W-1:0] cmag;
    logic [LANES-1:0]            neg;
  } nmit_det_t;

  typedef struct packed {
    logic                        singular;
    mat_t                        m;
    logic [DET_W-1:0]            d;
    logic [LANES-1:0][DET_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] q;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0]            ovf;
  } nmit_div_t;

endpackage

>>> hdl/normal_matrix_inverse_transpose_core.sv
// Top level of the normal matrix inverse transpose pipeline.
// The core takes one 3x3 transform per clock and returns its inverse transpose,
// one beat per beat in, with done high for one cycle; busy is always low and
// results cannot be held off. The pipeline is made of two cofactor stages, four
// determinant stages, one divider entry stage, 32 quotient stages (one per
// quotient bit) and one rounding and output stage.
module normal_matrix_inverse_transpose_core import nmit_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_we,
  input  logic [THR_W-1:0]         cfg_wdata,
  input  logic signed [ELEM_W-1:0] m00, m01, m02,
  input  logic signed [ELEM_W-1:0] m10, m11, m12,
  input  logic signed [ELEM_W-1:0] m20, m21, m22,
  output logic                     done,
  output logic signed [ELEM_W-1:0] n00, n01, n02,
  output logic signed [ELEM_W-1:0] n10, n11, n12,
  output logic signed [ELEM_W-1:0] n20, n21, n22,
  output logic                     singular
);

  logic [THR_W-1:0] thr;
  mat_t             m_in;
  nmit_cof_t        cof;
  nmit_det_t        det;
  nmit_div_t        dv;
  logic             dv_valid;
  mat_t             res_next;
  mat_t             res;

  assign busy = 1'b0;
  assign m_in = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  nmit_cofactor u_cof (
    .clk(clk), .rst(rst), .in_valid(start), .m_in(m_in), .cof_out(cof)
  );

  nmit_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk(clk), .rst(rst), .cof_in(cof), .thr(thr), .det_out(det)
  );

  nmit_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .det_in(det), .out_valid(dv_valid), .div_out(dv)
  );

  always_comb begin
    logic             rnd;
    logic [QUO_W:0]   qr;
    logic [QUO_W:0]   cap;
    logic [QUO_W:0]   mag;
    for (int k = 0; k < LANES; k++) begin
      rnd = {dv.rem[k], 1'b0} >= {1'b0, dv.d};
      qr  = {1'b0, dv.q[k]} + (QUO_W+1)'(rnd);
      cap = dv.neg[k] ? 33'h080000000 : 33'h07FFFFFFF;
      mag = (dv.ovf[k] || qr > cap) ? cap : qr;
      if (dv.singular) begin
        res_next[k] = dv.m[k];
      end else if (dv.neg[k]) begin
        res_next[k] = ~mag[ELEM_W-1:0] + 1'b1;
      end else begin
        res_next[k] = mag[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    res      <= res_next;
    singular <= dv.singular;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  assign n00 = res[0];
  assign n01 = res[1];
  assign n02 = res[2];
  assign n10 = res[3];
  assign n11 = res[4];
  assign n12 = res[5];
  assign n20 = res[6];
  assign n21 = res[7];
  assign n22 = res[8];

endmodule

>>> hdl/nmit_cofactor.sv
// Two-stage cofactor unit: eighteen products, then nine differences.
module nmit_cofactor import nmit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  mat_t      m_in,
  output nmit_cof_t cof_out
);

  logic [LANES-1:0][COF_W-1:0] pp;
  logic [LANES-1:0][COF_W-1:0] qq;
  mat_t                        m1;
  mat_t                        m2;
  logic [LANES-1:0][COF_W-1:0] cof;
  logic                        vld1;
  logic                        vld2;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int R  = k / 3;
    localparam int C  = k % 3;
    localparam int IA = ((R + 1) % 3) * 3 + (C + 1) % 3;
    localparam int IB = ((R + 2) % 3) * 3 + (C + 2) % 3;
    localparam int IC = ((R + 1) % 3) * 3 + (C + 2) % 3;
    localparam int ID = ((R + 2) % 3) * 3 + (C + 1) % 3;
    logic signed [ELEM_W-1:0] xa, xb, xc, xd;
    logic signed [COF_W-1:0]  prod_p, prod_q;
    assign xa = m_in[IA];
    assign xb = m_in[IB];
    assign xc = m_in[IC];
    assign xd = m_in[ID];
    assign prod_p = xa * xb;
    assign prod_q = xc * xd;
    always_ff @(posedge clk) begin
      pp[k]  <= prod_p;
      qq[k]  <= prod_q;
      cof[k] <= pp[k] - qq[k];
    end
  end

  always_ff @(posedge clk) begin
    m1 <= m_in;
    m2 <= m1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
    end
  end

  assign cof_out.valid = vld2;
  assign cof_out.m     = m2;
  assign cof_out.cof   = cof;

endmodule

>>> hdl/nmit_det.sv
// Four-stage determinant unit with magnitude, singular test and cofactor magnitudes.
module nmit_det import nmit_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  nmit_cof_t        cof_in,
  input  logic [THR_W-1:0] thr,
  output nmit_det_t        det_out
);

  logic [3:0]                        vld;
  mat_t                              m3, m4, m5, m6;
  logic [LANES-1:0][COF_W-1:0]       c3, c4, c5;
  logic [2:0][COF_W-1:0]             pl, ph;
  logic [2:0]                        sgn;
  logic [2:0][DET_W-1:0]             term;
  logic [DET_W-1:0]                  det;
  logic [DET_W-1:0]                  dmag;
  logic                              sing;
  logic [LANES-1:0][COF_W-1:0]       cmag;
  logic [LANES-1:0]                  neg;

  logic [2:0][ELEM_W-1:0]            am;
  logic [2:0][COF_W-1:0]             cm;
  logic [2:0][DET_W-1:0]             term_next;
  logic                              dneg;
  logic [DET_W-1:0]                  dmag_next;
  logic [DET_W-1:0]                  limit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      am[c] = cof_in.m[c][ELEM_W-1] ? ELEM_W'(~cof_in.m[c] + 1'b1) : cof_in.m[c];
      cm[c] = cof_in.cof[c][COF_W-1] ? COF_W'(~cof_in.cof[c] + 1'b1) : cof_in.cof[c];
      term_next[c] = (DET_W'(ph[c]) << 32) + DET_W'(pl[c]);
      if (sgn[c]) begin
        term_next[c] = ~term_next[c] + 1'b1;
      end
    end
  end

  assign dneg      = det[DET_W-1];
  assign dmag_next = dneg ? (~det + 1'b1) : det;
  assign limit     = DET_W'(thr) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      pl[c]  <= COF_W'(am[c]) * COF_W'(cm[c][31:0]);
      ph[c]  <= COF_W'(am[c]) * COF_W'(cm[c][63:32]);
      sgn[c] <= cof_in.m[c][ELEM_W-1] ^ cof_in.cof[c][COF_W-1];
    end
    term <= term_next;
    det  <= term[0] + term[1] + term[2];
    dmag <= dmag_next;
    sing <= limit >= dmag_next;
    for (int k = 0; k < LANES; k++) begin
      cmag[k] <= c5[k][COF_W-1] ? COF_W'(~c5[k] + 1'b1) : c5[k];
      neg[k]  <= c5[k][COF_W-1] ^ dneg;
    end
    m3 <= cof_in.m;
    m4 <= m3;
    m5 <= m4;
    m6 <= m5;
    c3 <= cof_in.cof;
    c4 <= c3;
    c5 <= c4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], cof_in.valid};
    end
  end

  assign det_out.valid    = vld[3];
  assign det_out.singular = sing;
  assign det_out.m        = m6;
  assign det_out.d        = dmag;
  assign det_out.cmag     = cmag;
  assign det_out.neg      = neg;

endmodule

>>> hdl/nmit_div.sv
// Pipelined restoring divider: one quotient bit per stage for all nine lanes.
module nmit_div import nmit_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  input  nmit_det_t det_in,
  output logic      out_valid,
  output nmit_div_t div_out
);

  nmit_div_t        st [0:QUO_W];
  logic [QUO_W:0]   vld;
  nmit_div_t        entry;

  always_comb begin
    entry.singular = det_in.singular;
    entry.m        = det_in.m;
    entry.d        = det_in.d;
    entry.neg      = det_in.neg;
    entry.q        = '0;
    for (int k = 0; k < LANES; k++) begin
      entry.rem[k] = DET_W'(det_in.cmag[k]) << (2 * FRAC_BITS);
      entry.ovf[k] = {32'b0, entry.rem[k]} >= {det_in.d, 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= entry;
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int SH = QUO_W - 1 - j;
    nmit_div_t nxt;
    always_comb begin
      logic [DET_W+QUO_W-1:0] dsh;
      logic [DET_W+QUO_W-1:0] r;
      nxt = st[j];
      dsh = {32'b0, st[j].d} << SH;
      for (int k = 0; k < LANES; k++) begin
        r = {32'b0, st[j].rem[k]};
        if (r >= dsh) begin
          nxt.rem[k]   = DET_W'(r - dsh);
          nxt.q[k][SH] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      st[j+1] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QUO_W-1:0], det_in.valid};
    end
  end

  assign out_valid = vld[QUO_W];
  assign div_out   = st[QUO_W];

endmodule
